/* hw/rtl/lts_pkg.sv */
// Shared types, constants and functions for the lexical token scanner.
package lts_pkg;

    localparam int KEYWORD_CHARS = 8;
    localparam int QUEUE_DEPTH   = 4;
    localparam int KW_COUNT      = 13;
    localparam int KW_MAX_LEN    = 8;

    localparam logic [3:0] KW_NONE = 4'(KW_COUNT);

    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "function", "return", "integer", "int", "real", "boolean", "if",
        "fi", "else", "read", "write", "while", "for"
    };
    localparam int KW_LEN [KW_COUNT] = '{8, 6, 7, 3, 4, 7, 2, 2, 4, 4, 5, 5, 3};

    localparam logic [2:0] TK_SEP  = 3'd0;
    localparam logic [2:0] TK_OPER = 3'd1;
    localparam logic [2:0] TK_INT  = 3'd2;
    localparam logic [2:0] TK_REAL = 3'd3;
    localparam logic [2:0] TK_KEYW = 3'd4;
    localparam logic [2:0] TK_IDEN = 3'd5;
    localparam logic [2:0] TK_BAD  = 3'd6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    localparam logic [15:0] LEN_ONE = 16'd1;
    localparam logic [15:0] LEN_TWO = 16'd2;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_DOLLAR,
        SCAN_OP,
        SCAN_INT,
        SCAN_REAL,
        SCAN_WORD,
        SCAN_HALT
    } scan_mode_t;

    typedef enum logic [3:0] {
        CC_SPACE,
        CC_DOLLAR,
        CC_OPHOLD,
        CC_SEP,
        CC_OPER,
        CC_DIGIT,
        CC_ALPHA,
        CC_DOT,
        CC_BAD
    } char_class_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } in_word_t;

    typedef struct packed {
        in_word_t    item;
        char_class_t cls;
    } front_word_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic [3:0]  keyword_index;
        logic [7:0]  symbol_first;
        logic [7:0]  symbol_second;
        logic        last;
    } result_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    function automatic char_class_t char_class(input logic [7:0] c);
        char_class_t cls;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
            cls = CC_SPACE;
        else if (c == CH_DOLLAR)
            cls = CC_DOLLAR;
        else if (c == CH_EQ || c == 8'h21 || c == 8'h3C || c == 8'h3E)
            cls = CC_OPHOLD;
        else if (c == 8'h28 || c == 8'h29 || c == 8'h3B || c == 8'h2C
                 || c == 8'h7B || c == 8'h7D)
            cls = CC_SEP;
        else if (c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F)
            cls = CC_OPER;
        else if (c >= 8'h30 && c <= 8'h39)
            cls = CC_DIGIT;
        else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
            cls = CC_ALPHA;
        else if (c == CH_DOT)
            cls = CC_DOT;
        else
            cls = CC_BAD;
        return cls;
    endfunction

    // chars holds byte i at [8*i +: 8]; first matching keyword wins.
    function automatic logic [3:0] kw_find(input logic [8*KW_MAX_LEN-1:0] chars,
                                           input logic [15:0] len);
        logic [3:0] idx;
        logic       same;
        logic [7:0] kb;
        idx = KW_NONE;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            same = (len == 16'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++)
            begin
                if (i < KW_LEN[k])
                begin
                    kb   = 8'(KW_TEXT[k] >> (8 * (KW_LEN[k] - 1 - i)));
                    same = same && (chars[8*i +: 8] == kb);
                end
            end
            if (same)
                idx = 4'(k);
        end
        return idx;
    endfunction

endpackage

/* hw/rtl/lts_fifo.sv */
// Small register-based FIFO, used for the item queue and the result queue of the scanner.
module lts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lts_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 pop,
    output logic [WIDTH-1:0]     rdata,
    output lts_pkg::fifo_status_t status
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

endmodule

/* hw/rtl/lts_front.sv */
// Front end: accepts input words and tags each byte with its character class.
module lts_front (
    input  logic                  push,
    output logic                  full,
    input  lts_pkg::in_word_t     item,
    input  lts_pkg::fifo_status_t q_status,
    output logic                  q_push,
    output lts_pkg::front_word_t  q_word
);
    assign full        = q_status.full;
    assign q_push      = push && !q_status.full;
    assign q_word.item = item;
    assign q_word.cls  = lts_pkg::char_class(item.ch);

endmodule

/* hw/rtl/lts_back.sv */
// Back end: token state machine, keyword match and result emission.
module lts_back #(
    parameter int KEYWORD_CHARS = lts_pkg::KEYWORD_CHARS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lts_pkg::fifo_status_t q_status,
    input  lts_pkg::front_word_t  q_word,
    output logic                  q_pop,
    input  lts_pkg::fifo_status_t o_status,
    output logic                  o_push,
    output lts_pkg::result_t      o_word
);
    localparam int IW = $clog2(KEYWORD_CHARS);

    lts_pkg::scan_mode_t mode_reg, mode_next;
    logic [15:0]         plen_reg, plen_next;
    logic [31:0]         pos_reg, pos_next;
    logic [31:0]         pstart_reg, pstart_next;
    logic [7:0]          held_reg, held_next;
    lts_pkg::result_t    hold_reg, hold_next;
    logic                hold_valid_reg, hold_valid_next;

    logic [7:0]          word_chars_reg [KEYWORD_CHARS];
    logic [8*lts_pkg::KW_MAX_LEN-1:0] wc_flat;
    logic                wc_we;
    logic [IW-1:0]       wc_idx;

    logic                take, flush_en, start_en, pair_en;
    logic                f_valid, s_valid, fv, sv;
    lts_pkg::result_t    f_res, s_res, pair_res, a_res, b_res;
    logic [3:0]          kw_idx;
    logic [15:0]         plen_grow;
    logic [7:0]          c;
    lts_pkg::char_class_t cls;

    always_comb
    begin
        for (int i = 0; i < lts_pkg::KW_MAX_LEN; i++)
            wc_flat[8*i +: 8] = word_chars_reg[i];
    end

    assign c         = q_word.item.ch;
    assign cls       = q_word.cls;
    assign kw_idx    = lts_pkg::kw_find(wc_flat, plen_reg);
    assign plen_grow = (plen_reg == lts_pkg::LEN_MAX) ? plen_reg : plen_reg + 16'd1;
    assign take      = !q_status.empty && !hold_valid_reg && !o_status.full;
    assign q_pop     = take;

    // pending token as it would be flushed
    always_comb
    begin
        f_res              = '0;
        f_res.start_offset = pstart_reg;
        f_res.token_length = plen_reg;
        f_valid            = 1'b1;
        unique case (mode_reg)
            lts_pkg::SCAN_DOLLAR:
            begin
                f_res.token_kind   = lts_pkg::TK_SEP;
                f_res.token_length = lts_pkg::LEN_ONE;
                f_res.symbol_first = lts_pkg::CH_DOLLAR;
            end
            lts_pkg::SCAN_OP:
            begin
                f_res.token_kind   = lts_pkg::TK_OPER;
                f_res.token_length = lts_pkg::LEN_ONE;
                f_res.symbol_first = held_reg;
            end
            lts_pkg::SCAN_INT:  f_res.token_kind = lts_pkg::TK_INT;
            lts_pkg::SCAN_REAL: f_res.token_kind = lts_pkg::TK_REAL;
            lts_pkg::SCAN_WORD:
            begin
                if (kw_idx == lts_pkg::KW_NONE)
                    f_res.token_kind = lts_pkg::TK_IDEN;
                else
                begin
                    f_res.token_kind    = lts_pkg::TK_KEYW;
                    f_res.keyword_index = kw_idx;
                end
            end
            default: f_valid = 1'b0;
        endcase
    end

    // immediate single-character token for the current byte
    always_comb
    begin
        s_res              = '0;
        s_res.start_offset = pos_reg;
        s_res.token_length = lts_pkg::LEN_ONE;
        s_res.symbol_first = c;
        s_valid            = 1'b1;
        unique case (cls)
            lts_pkg::CC_SEP:  s_res.token_kind = lts_pkg::TK_SEP;
            lts_pkg::CC_OPER: s_res.token_kind = lts_pkg::TK_OPER;
            lts_pkg::CC_DOT,
            lts_pkg::CC_BAD:  s_res.token_kind = lts_pkg::TK_BAD;
            default:          s_valid = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        plen_next   = plen_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        held_next   = held_reg;
        flush_en    = 1'b0;
        start_en    = 1'b0;
        pair_en     = 1'b0;
        pair_res    = '0;
        wc_we       = 1'b0;
        wc_idx      = plen_reg[IW-1:0];

        pair_res.start_offset = pstart_reg;
        pair_res.token_length = lts_pkg::LEN_TWO;

        if (take && mode_reg != lts_pkg::SCAN_HALT)
        begin
            if (q_word.item.kind)
                flush_en = 1'b1;
            else
            begin
                pos_next = pos_reg + 32'd1;
                unique case (mode_reg)
                    lts_pkg::SCAN_DOLLAR:
                    begin
                        if (cls == lts_pkg::CC_DOLLAR)
                        begin
                            pair_en                = 1'b1;
                            pair_res.token_kind    = lts_pkg::TK_SEP;
                            pair_res.symbol_first  = lts_pkg::CH_DOLLAR;
                            pair_res.symbol_second = lts_pkg::CH_DOLLAR;
                            mode_next              = lts_pkg::SCAN_IDLE;
                        end
                        else
                        begin
                            flush_en = 1'b1;
                            start_en = 1'b1;
                        end
                    end
                    lts_pkg::SCAN_OP:
                    begin
                        if (c == lts_pkg::CH_EQ)
                        begin
                            pair_en                = 1'b1;
                            pair_res.token_kind    = lts_pkg::TK_OPER;
                            pair_res.symbol_first  = held_reg;
                            pair_res.symbol_second = lts_pkg::CH_EQ;
                            mode_next              = lts_pkg::SCAN_IDLE;
                        end
                        else
                        begin
                            flush_en = 1'b1;
                            start_en = 1'b1;
                        end
                    end
                    lts_pkg::SCAN_INT,
                    lts_pkg::SCAN_REAL:
                    begin
                        if (cls == lts_pkg::CC_DIGIT)
                            plen_next = plen_grow;
                        else if (cls == lts_pkg::CC_DOT && mode_reg == lts_pkg::SCAN_INT)
                        begin
                            plen_next = plen_grow;
                            mode_next = lts_pkg::SCAN_REAL;
                        end
                        else
                        begin
                            flush_en = 1'b1;
                            start_en = 1'b1;
                        end
                    end
                    lts_pkg::SCAN_WORD:
                    begin
                        if (cls == lts_pkg::CC_ALPHA || cls == lts_pkg::CC_DIGIT)
                        begin
                            wc_we     = (plen_reg < 16'(KEYWORD_CHARS));
                            plen_next = plen_grow;
                        end
                        else
                        begin
                            flush_en = 1'b1;
                            start_en = 1'b1;
                        end
                    end
                    default: start_en = 1'b1;
                endcase
            end

            if (flush_en)
                mode_next = lts_pkg::SCAN_IDLE;

            if (start_en)
            begin
                unique case (cls)
                    lts_pkg::CC_DOLLAR,
                    lts_pkg::CC_OPHOLD:
                    begin
                        mode_next   = (cls == lts_pkg::CC_DOLLAR) ? lts_pkg::SCAN_DOLLAR
                                                                  : lts_pkg::SCAN_OP;
                        held_next   = c;
                        pstart_next = pos_reg;
                        plen_next   = lts_pkg::LEN_ONE;
                    end
                    lts_pkg::CC_DIGIT:
                    begin
                        mode_next   = lts_pkg::SCAN_INT;
                        pstart_next = pos_reg;
                        plen_next   = lts_pkg::LEN_ONE;
                    end
                    lts_pkg::CC_ALPHA:
                    begin
                        mode_next   = lts_pkg::SCAN_WORD;
                        pstart_next = pos_reg;
                        plen_next   = lts_pkg::LEN_ONE;
                        wc_we       = 1'b1;
                        wc_idx      = '0;
                    end
                    lts_pkg::CC_DOT,
                    lts_pkg::CC_BAD: mode_next = lts_pkg::SCAN_HALT;
                    default: ;
                endcase
            end
        end
    end

    // result assembly: up to two per item, the second parked in hold_reg
    assign fv = flush_en && f_valid;
    assign sv = start_en && s_valid;

    always_comb
    begin
        if (fv)
            a_res = f_res;
        else if (pair_en)
            a_res = pair_res;
        else
            a_res = s_res;
        a_res.last = !(fv && sv);
        b_res      = s_res;
        b_res.last = 1'b1;

        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (hold_valid_reg)
        begin
            o_push = !o_status.full;
            o_word = hold_reg;
            if (!o_status.full)
                hold_valid_next = 1'b0;
        end
        else
        begin
            o_push = take && (fv || sv || pair_en);
            o_word = a_res;
            if (take && fv && sv)
            begin
                hold_valid_next = 1'b1;
                hold_next       = b_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= lts_pkg::SCAN_IDLE;
            plen_reg       <= '0;
            pos_reg        <= '0;
            pstart_reg     <= '0;
            held_reg       <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            plen_reg       <= plen_next;
            pos_reg        <= pos_next;
            pstart_reg     <= pstart_next;
            held_reg       <= held_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (wc_we)
            word_chars_reg[wc_idx] <= c;
    end

endmodule

/* hw/rtl/lexical_token_scanner.sv */
// Top level of the lexical token scanner: front end, queues and back end.
// An accepted input word is registered in the item queue, and its results are registered in the output queue.
// Throughput: one input word per cycle while neither queue is full; a word that yields two tokens
// stalls the back end while the second waits in its hold register, set by its single output queue write port.
// Reset clears both queues and all scan state; the keyword buffer is not cleared.
module lexical_token_scanner #(
    parameter int KEYWORD_CHARS = lts_pkg::KEYWORD_CHARS,
    parameter int QUEUE_DEPTH   = lts_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  lts_pkg::in_word_t item,
    output logic              empty,
    input  logic              pop,
    output lts_pkg::result_t  result
);
    lts_pkg::fifo_status_t q_status, o_status;
    lts_pkg::front_word_t  fq_wdata, fq_rdata;
    lts_pkg::result_t      o_wdata;
    logic                  fq_push, fq_pop, o_push;

    lts_front u_front (
        .push     (push),
        .full     (full),
        .item     (item),
        .q_status (q_status),
        .q_push   (fq_push),
        .q_word   (fq_wdata)
    );

    lts_fifo #(
        .WIDTH ($bits(lts_pkg::front_word_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (fq_push),
        .wdata  (fq_wdata),
        .pop    (fq_pop),
        .rdata  (fq_rdata),
        .status (q_status)
    );

    lts_back #(
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_word   (fq_rdata),
        .q_pop    (fq_pop),
        .o_status (o_status),
        .o_push   (o_push),
        .o_word   (o_wdata)
    );

    lts_fifo #(
        .WIDTH ($bits(lts_pkg::result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (o_push),
        .wdata  (o_wdata),
        .pop    (pop),
        .rdata  (result),
        .status (o_status)
    );

    assign empty = o_status.empty;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for lexical_token_scanner: directed and random token streams against a predictor.
module testbench;

    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_END    = 1'b1;
    localparam int   CYCLE_LIMIT = 1000000;

    class token_scoreboard;
        string keywords[13] = '{"function", "return", "integer", "int", "real", "boolean",
                                "if", "fi", "else", "read", "write", "while", "for"};
        lts_pkg::scan_mode_t mode   = lts_pkg::SCAN_IDLE;
        logic [7:0]          wbuf [lts_pkg::KEYWORD_CHARS];
        logic [15:0]         plen   = '0;
        logic [31:0]         pos    = '0;
        logic [31:0]         pstart = '0;
        logic [7:0]          held   = '0;
        lts_pkg::result_t    step_out[$];
        lts_pkg::result_t    due_tokens[$];
        int                  mismatches = 0;

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function void emit(logic [2:0] kind, logic [31:0] start, logic [15:0] len,
                           logic [3:0] kwi, logic [7:0] s1, logic [7:0] s2);
            lts_pkg::result_t t;
            t.token_kind    = kind;
            t.start_offset  = start;
            t.token_length  = len;
            t.keyword_index = kwi;
            t.symbol_first  = s1;
            t.symbol_second = s2;
            t.last          = 1'b0;
            step_out.push_back(t);
        endfunction

        function void lengthen();
            if (plen != lts_pkg::LEN_MAX)
                plen++;
        endfunction

        function void flush_pending();
            int found;
            bit same;
            found = -1;
            case (mode)
                lts_pkg::SCAN_DOLLAR:
                    emit(lts_pkg::TK_SEP, pstart, lts_pkg::LEN_ONE, '0, lts_pkg::CH_DOLLAR, '0);
                lts_pkg::SCAN_OP:
                    emit(lts_pkg::TK_OPER, pstart, lts_pkg::LEN_ONE, '0, held, '0);
                lts_pkg::SCAN_INT:  emit(lts_pkg::TK_INT, pstart, plen, '0, '0, '0);
                lts_pkg::SCAN_REAL: emit(lts_pkg::TK_REAL, pstart, plen, '0, '0, '0);
                lts_pkg::SCAN_WORD:
                begin
                    for (int k = 12; k >= 0; k--)
                    begin
                        if (plen == 16'(keywords[k].len()))
                        begin
                            same = 1'b1;
                            for (int i = 0; i < keywords[k].len(); i++)
                                if (wbuf[i] != keywords[k][i])
                                    same = 1'b0;
                            if (same)
                                found = k;
                        end
                    end
                    if (found >= 0)
                        emit(lts_pkg::TK_KEYW, pstart, plen, 4'(found), '0, '0);
                    else
                        emit(lts_pkg::TK_IDEN, pstart, plen, '0, '0, '0);
                end
                default: ;
            endcase
            if (mode != lts_pkg::SCAN_HALT)
                mode = lts_pkg::SCAN_IDLE;
        endfunction

        function void open_token(logic [7:0] c, logic [31:0] p);
            if (c == " " || (c >= 8'h09 && c <= 8'h0D))
                return;
            if (c == lts_pkg::CH_DOLLAR || c == lts_pkg::CH_EQ || c == "!" || c == "<"
                || c == ">")
            begin
                mode   = (c == lts_pkg::CH_DOLLAR) ? lts_pkg::SCAN_DOLLAR : lts_pkg::SCAN_OP;
                held   = c;
                pstart = p;
                plen   = lts_pkg::LEN_ONE;
            end
            else if (c inside {"(", ")", ";", ",", "{", "}"})
                emit(lts_pkg::TK_SEP, p, lts_pkg::LEN_ONE, '0, c, '0);
            else if (c inside {"+", "-", "*", "/"})
                emit(lts_pkg::TK_OPER, p, lts_pkg::LEN_ONE, '0, c, '0);
            else if (is_digit(c))
            begin
                mode   = lts_pkg::SCAN_INT;
                pstart = p;
                plen   = lts_pkg::LEN_ONE;
            end
            else if (is_alpha(c))
            begin
                mode    = lts_pkg::SCAN_WORD;
                pstart  = p;
                plen    = lts_pkg::LEN_ONE;
                wbuf[0] = c;
            end
            else
            begin
                emit(lts_pkg::TK_BAD, p, lts_pkg::LEN_ONE, '0, c, '0);
                mode = lts_pkg::SCAN_HALT;
            end
        endfunction

        // Predicts the tokens caused by one accepted input word.
        function void scan_word(lts_pkg::in_word_t w);
            logic [31:0] p;
            logic [7:0]  c;
            if (mode == lts_pkg::SCAN_HALT)
                return;
            step_out.delete();
            c = w.ch;
            if (w.kind == KIND_END)
                flush_pending();
            else
            begin
                p   = pos;
                pos = pos + 1;
                case (mode)
                    lts_pkg::SCAN_DOLLAR, lts_pkg::SCAN_OP:
                    begin
                        if (mode == lts_pkg::SCAN_DOLLAR && c == lts_pkg::CH_DOLLAR)
                        begin
                            emit(lts_pkg::TK_SEP, pstart, lts_pkg::LEN_TWO, '0,
                                 lts_pkg::CH_DOLLAR, lts_pkg::CH_DOLLAR);
                            mode = lts_pkg::SCAN_IDLE;
                        end
                        else if (mode == lts_pkg::SCAN_OP && c == lts_pkg::CH_EQ)
                        begin
                            emit(lts_pkg::TK_OPER, pstart, lts_pkg::LEN_TWO, '0, held,
                                 lts_pkg::CH_EQ);
                            mode = lts_pkg::SCAN_IDLE;
                        end
                        else
                        begin
                            flush_pending();
                            open_token(c, p);
                        end
                    end
                    lts_pkg::SCAN_INT, lts_pkg::SCAN_REAL:
                    begin
                        if (is_digit(c))
                            lengthen();
                        else if (c == lts_pkg::CH_DOT && mode == lts_pkg::SCAN_INT)
                        begin
                            lengthen();
                            mode = lts_pkg::SCAN_REAL;
                        end
                        else
                        begin
                            flush_pending();
                            open_token(c, p);
                        end
                    end
                    lts_pkg::SCAN_WORD:
                    begin
                        if (is_alpha(c) || is_digit(c))
                        begin
                            if (plen < lts_pkg::KEYWORD_CHARS)
                                wbuf[plen] = c;
                            lengthen();
                        end
                        else
                        begin
                            flush_pending();
                            open_token(c, p);
                        end
                    end
                    default: open_token(c, p);
                endcase
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                due_tokens.push_back(step_out[i]);
        endfunction

        function void check_token(lts_pkg::result_t got);
            lts_pkg::result_t want;
            if (due_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected: kind %0d start %0d len %0d kw %0d sym %02h/%02h",
                             got.token_kind, got.start_offset, got.token_length,
                             got.keyword_index, got.symbol_first, got.symbol_second);
                return;
            end
            want = due_tokens.pop_front();
            if (got.token_kind !== want.token_kind || got.start_offset !== want.start_offset
                || got.token_length !== want.token_length
                || got.keyword_index !== want.keyword_index
                || got.symbol_first !== want.symbol_first
                || got.symbol_second !== want.symbol_second || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("expected: kind %0d start %0d len %0d kw %0d sym %02h/%02h last %0b",
                             want.token_kind, want.start_offset, want.token_length,
                             want.keyword_index, want.symbol_first, want.symbol_second,
                             want.last);
                    $display("  actual: kind %0d start %0d len %0d kw %0d sym %02h/%02h last %0b",
                             got.token_kind, got.start_offset, got.token_length,
                             got.keyword_index, got.symbol_first, got.symbol_second,
                             got.last);
                end
            end
        endfunction
    endclass

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              push  = 1'b0;
    logic              full;
    lts_pkg::in_word_t item  = '0;
    logic              empty;
    logic              pop   = 1'b0;
    lts_pkg::result_t  result;

    token_scoreboard sb = new();

    int send_idle   = 0;
    int recv_idle   = 0;
    int hold_cycles = 0;
    int words_sent  = 0;

    string digit_pool  = "0123456789";
    string letter_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string sep_pool    = "();,{}";
    string op_pool     = "+-*/=!<>";
    string hold_pool   = "=!<>";
    string bad_pool    = "#@_?:[]^`~|&%'\\\"";
    string alnum_pool;
    string space_pool;
    string valid_pool;

    lexical_token_scanner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            sb.scan_word(item);
        if (rst_n && pop && !empty)
            sb.check_token(result);
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_word(input lts_pkg::in_word_t w);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(lts_pkg::in_word_t'{kind: KIND_CHAR, ch: s[i]});
    endtask

    task automatic send_end();
        send_word(lts_pkg::in_word_t'{kind: KIND_END, ch: 8'($urandom_range(255))});
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.due_tokens.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick(string pool);
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    function automatic string random_run(string pool, int n);
        string s;
        s = "";
        repeat (n)
            s = $sformatf("%s%c", s, pick(pool));
        return s;
    endfunction

    // Reals always get leading whitespace so a preceding word or real cannot absorb the digits.
    function automatic string random_lexeme();
        string s;
        s = "";
        case ($urandom_range(11))
            0, 1: s = sb.keywords[$urandom_range(12)];
            2:
            begin
                s = sb.keywords[$urandom_range(12)];
                case ($urandom_range(2))
                    0:       s = s.substr(0, s.len() - 2);
                    1:       s = $sformatf("%s%c", s, pick(alnum_pool));
                    default: s = s.toupper();
                endcase
            end
            3, 4: s = $sformatf("%c%s", pick(letter_pool),
                                random_run(alnum_pool, $urandom_range(0, 6)));
            5:    s = $sformatf("%c%s", pick(letter_pool),
                                random_run(alnum_pool, $urandom_range(8, 19)));
            6:    s = random_run(digit_pool, $urandom_range(1, 6));
            7:    s = $sformatf("%c%s.%s", pick(space_pool),
                                random_run(digit_pool, $urandom_range(1, 4)),
                                random_run(digit_pool, $urandom_range(0, 3)));
            8:    s = random_run(sep_pool, 1);
            9:    s = $urandom_range(1) ? "$$" : "$";
            10:   s = random_run(op_pool, 1);
            default: s = $sformatf("%c=", pick(hold_pool));
        endcase
        return s;
    endfunction

    task automatic random_stream(input int count);
        int target;
        int r;
        target = words_sent + count;
        while (words_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 72)
            begin
                send_text(random_lexeme());
                if ($urandom_range(1))
                    send_text(random_run(space_pool, $urandom_range(1, 2)));
            end
            else if (r < 88)
                send_text(random_run(valid_pool, 1));
            else if (r < 95)
                send_end();
            else
                send_text(random_run(space_pool, $urandom_range(1, 4)));
        end
    endtask

    initial
    begin
        logic [7:0] bad_char;
        alnum_pool = {letter_pool, digit_pool};
        space_pool = $sformatf("%c%c%c%c%c%c", 8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D);
        valid_pool = {alnum_pool, sep_pool, "$", op_pool, space_pool};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle = 32;
        recv_idle = 69;
        send_word(lts_pkg::in_word_t'{kind: KIND_END, ch: 8'hFF});
        send_text($sformatf("$$$(<=!x 12.5+for%c9a", 8'h09));
        send_word(lts_pkg::in_word_t'{kind: KIND_END, ch: 8'h00});

        // receiver stalls long enough for both queues to back up
        hold_cycles = 120;
        repeat (30)
            send_text(random_run(sep_pool, 1));
        drain();
        random_stream(460);
        drain();

        send_idle = 69;
        recv_idle = 32;
        random_stream(470);
        drain();

        send_idle = 0;
        recv_idle = 0;
        random_stream(470);
        drain();

        // halt: invalid byte after a pending token, then words that must yield nothing
        case ($urandom_range(2))
            0:       send_text($sformatf(" %s.%s.", random_run(digit_pool, 2),
                                         random_run(digit_pool, $urandom_range(0, 2))));
            1:
            begin
                send_text(" ab");
                send_word(lts_pkg::in_word_t'{kind: KIND_CHAR,
                                              ch: 8'($urandom_range(128, 255))});
            end
            default:
            begin
                bad_char = $urandom_range(1) ? pick(bad_pool) : 8'($urandom_range(14, 31));
                send_text(" $");
                send_word(lts_pkg::in_word_t'{kind: KIND_CHAR, ch: bad_char});
            end
        endcase
        repeat (12)
            send_word(lts_pkg::in_word_t'{kind: 1'($urandom_range(1)),
                                          ch: 8'($urandom_range(255))});
        drain();
        repeat (20) @(negedge clk);

        if (sb.mismatches == 0 && sb.due_tokens.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
